FILE: rtl/core/pcm_pkg.sv
package pcm_pkg;

    localparam int MAX_POINTS_DEF    = 64;
    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int POL_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    localparam logic [POL_W-1:0] POL_UNCHANGED  = 3'd0;
    localparam logic [POL_W-1:0] POL_ZERO       = 3'd1;
    localparam logic [POL_W-1:0] POL_ONE_TO_ONE = 3'd2;
    localparam logic [POL_W-1:0] POL_MEAN       = 3'd3;
    localparam logic [POL_W-1:0] POL_NEAREST    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POL_BELOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POL_ABOVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd2;

    typedef struct packed {
        logic go;
        logic div_only;
    } t_md_ctrl;

endpackage

FILE: rtl/core/pcm_front.sv
module pcm_front #(
    parameter int VALUE_WIDTH = pcm_pkg::VALUE_WIDTH_DEF,
    parameter int ITEM_W      = 1 + pcm_pkg::IDX_W + 3 * pcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic [pcm_pkg::IDX_W-1:0] i_point_index,
    input  logic [VALUE_WIDTH-1:0]   i_ref_value,
    input  logic [VALUE_WIDTH-1:0]   i_fcst_value,
    input  logic [VALUE_WIDTH-1:0]   i_sample,
    output logic                     o_avail,
    output logic [ITEM_W-1:0]        o_item,
    input  logic                     i_pop
);
    localparam int DEPTH = pcm_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [ITEM_W-1:0] r_q [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [PW:0]       r_cnt;
    logic              push;
    logic              pop;

    assign o_stall = (r_cnt == (PW+1)'(DEPTH));
    assign push    = i_valid && !o_stall;
    assign o_avail = (r_cnt != '0);
    assign pop     = i_pop && o_avail;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= {i_command, i_point_index, i_ref_value, i_fcst_value, i_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: rtl/core/pcm_muldiv.sv
module pcm_muldiv #(
    parameter int VALUE_WIDTH = pcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcm_pkg::t_md_ctrl i_ctrl,
    input  logic [VALUE_WIDTH:0]       i_ma,
    input  logic [VALUE_WIDTH:0]       i_mb,
    input  logic [VALUE_WIDTH:0]       i_md,
    input  logic [2*VALUE_WIDTH+1:0]   i_dividend,
    output logic              o_done,
    output logic [2*VALUE_WIDTH+1:0]   o_q
);
    localparam int W  = VALUE_WIDTH;
    localparam int D  = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int NW = $clog2(PW + 1);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    logic [1:0]    r_state;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_mcand;
    logic [D-1:0]  r_mplier;
    logic [D-1:0]  r_d;
    logic [W+1:0]  r_rem;
    logic [NW-1:0] r_n;
    logic          r_done;
    logic [W+1:0]  rem_sh;
    logic          ge;

    assign rem_sh = {r_rem[W:0], r_p[PW-1]};
    assign ge     = (rem_sh >= (W+2)'(r_d));
    assign o_done = r_done;
    assign o_q    = r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_ctrl.go) begin
                        r_d   <= i_md;
                        r_n   <= '0;
                        r_rem <= '0;
                        if (i_ctrl.div_only) begin
                            r_p     <= i_dividend;
                            r_state <= M_DIV;
                        end else begin
                            r_p      <= '0;
                            r_mcand  <= PW'(i_ma);
                            r_mplier <= i_mb;
                            r_state  <= M_MUL;
                        end
                    end
                end
                M_MUL: begin
                    if (r_mplier[0]) r_p <= r_p + r_mcand;
                    r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[D-1:1]};
                    r_n      <= r_n + 1'b1;
                    if (r_n == NW'(D - 1)) begin
                        r_n     <= '0;
                        r_state <= M_DIV;
                    end
                end
                M_DIV: begin
                    r_rem <= ge ? (rem_sh - (W+2)'(r_d)) : rem_sh;
                    r_p   <= {r_p[PW-2:0], ge};
                    r_n   <= r_n + 1'b1;
                    if (r_n == NW'(PW - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/pcm_back.sv
module pcm_back #(
    parameter int MAX_POINTS  = pcm_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH = pcm_pkg::VALUE_WIDTH_DEF,
    parameter int ITEM_W      = 1 + pcm_pkg::IDX_W + 3 * pcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  logic [ITEM_W-1:0]             i_item,
    output logic                          o_pop,
    input  logic [pcm_pkg::POL_W-1:0]     i_pol_below,
    input  logic [pcm_pkg::POL_W-1:0]     i_pol_above,
    input  logic [pcm_pkg::COUNT_W-1:0]   i_point_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [VALUE_WIDTH-1:0]        o_mapped_value,
    output logic [pcm_pkg::STATUS_W-1:0]  o_status
);
    localparam int W  = VALUE_WIDTH;
    localparam int D  = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = W + CW;
    localparam int IX = pcm_pkg::IDX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_SEG  = 3'd4;
    localparam logic [2:0] S_MD   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic signed [W+2:0] VMAXX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] VMINX = {4'b1111, {(W-1){1'b0}}};
    localparam logic [W+1:0] QCLAMP = {1'b1, {(W+1){1'b0}}};

    function automatic logic [W-1:0] f_sat(input logic signed [W+2:0] v);
        logic [W-1:0] res;
        if (v > VMAXX) res = VMAXX[W-1:0];
        else if (v < VMINX) res = VMINX[W-1:0];
        else res = v[W-1:0];
        return res;
    endfunction

    logic [2*W-1:0] r_mem [MAX_POINTS];
    logic [2*W-1:0] r_rd_data;
    logic [AW-1:0]  rd_addr;

    logic [2:0]            r_state;
    logic [CW:0]           r_k;
    logic [CW-1:0]         r_c;
    logic signed [W-1:0]   r_x;
    logic signed [W-1:0]   r_f0, r_r0, r_f1, r_r1, r_fp, r_rp, r_fl, r_rl;
    logic signed [W-1:0]   r_pf, r_pr, r_lf, r_lr, r_uf, r_ur;
    logic signed [SW-1:0]  r_sum;
    logic [CW-1:0]         r_cnt;
    logic                  r_found;
    logic [D-1:0]          r_ma, r_mb, r_md;
    logic [PW-1:0]         r_dividend;
    logic                  r_neg;
    logic signed [W-1:0]   r_anchor;
    logic                  r_go;
    logic                  r_div_only;
    logic [W-1:0]          r_y;
    logic [pcm_pkg::STATUS_W-1:0] r_st;
    logic                  r_out_valid;
    logic [W-1:0]          r_out_val;
    logic [pcm_pkg::STATUS_W-1:0] r_out_st;

    logic                  it_cmd;
    logic [IX-1:0]         it_idx;
    logic [W-1:0]          it_ref, it_fcst, it_sample;
    logic [CW-1:0]         c_eff;
    logic signed [W-1:0]   cur_f, cur_r;

    logic                  below;
    logic [pcm_pkg::POL_W-1:0] pol;
    logic signed [W-1:0]   nref, nfcst;
    logic signed [D-1:0]   sel_dy, sel_dx, sel_dd;
    logic signed [W+2:0]   o2o;
    logic [D-1:0]          mag_dy, mag_dx, mag_dd;
    logic signed [SW-1:0]  sum_mag;
    logic                  is_inside;

    logic                  md_done;
    logic [PW-1:0]         md_q;
    logic [W+1:0]          q_clamped;
    logic signed [W+2:0]   fin_sum;
    pcm_pkg::t_md_ctrl     md_ctrl;

    assign it_cmd    = i_item[ITEM_W-1];
    assign it_idx    = i_item[ITEM_W-2 -: IX];
    assign it_ref    = i_item[3*W-1:2*W];
    assign it_fcst   = i_item[2*W-1:W];
    assign it_sample = i_item[W-1:0];
    assign c_eff     = (32'(i_point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                              : CW'(i_point_count);
    assign cur_r     = r_rd_data[2*W-1:W];
    assign cur_f     = r_rd_data[W-1:0];

    assign o_pop          = (r_state == S_IDLE) && i_avail;
    assign o_valid        = r_out_valid;
    assign o_mapped_value = r_out_val;
    assign o_status       = r_out_st;

    always_comb begin
        rd_addr = '0;
        unique case (r_state)
            S_RD: begin
                unique case (r_k[1:0])
                    2'd0:    rd_addr = '0;
                    2'd1:    rd_addr = (r_c > CW'(1)) ? AW'(1) : '0;
                    2'd2:    rd_addr = (r_c > CW'(1)) ? AW'(r_c - CW'(2)) : '0;
                    default: rd_addr = AW'(r_c - CW'(1));
                endcase
            end
            S_SCAN:  rd_addr = r_k[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && it_cmd == pcm_pkg::CMD_LOAD && 32'(it_idx) < MAX_POINTS) begin
            r_mem[AW'(it_idx)] <= {it_ref, it_fcst};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Segment or extrapolation operands
    always_comb begin
        below  = (r_x <= r_f0);
        pol    = below ? i_pol_below : i_pol_above;
        if (pol > pcm_pkg::POL_NEAREST) pol = pcm_pkg::POL_UNCHANGED;
        nref   = below ? r_r0 : r_rl;
        nfcst  = below ? r_f0 : r_fl;
        if (r_state == S_SEG) begin
            sel_dy = D'(r_ur) - D'(r_lr);
            sel_dx = D'(r_x) - D'(r_lf);
            sel_dd = D'(r_uf) - D'(r_lf);
        end else begin
            sel_dx = D'(r_x) - D'(nfcst);
            if (pol == pcm_pkg::POL_MEAN) begin
                sel_dy = D'(r_rl) - D'(r_r0);
                sel_dd = D'(r_fl) - D'(r_f0);
            end else if (below) begin
                sel_dy = D'(r_r1) - D'(r_r0);
                sel_dd = D'(r_f1) - D'(r_f0);
            end else begin
                sel_dy = D'(r_rl) - D'(r_rp);
                sel_dd = D'(r_fl) - D'(r_fp);
            end
        end
        mag_dy    = sel_dy[D-1] ? D'(-sel_dy) : D'(sel_dy);
        mag_dx    = sel_dx[D-1] ? D'(-sel_dx) : D'(sel_dx);
        mag_dd    = sel_dd[D-1] ? D'(-sel_dd) : D'(sel_dd);
        o2o       = (W+3)'(nref) + (W+3)'(sel_dx);
        sum_mag   = r_sum[SW-1] ? -r_sum : r_sum;
        is_inside = (r_x >= r_f0) && (r_x <= r_fl);
    end

    always_comb begin
        q_clamped = (md_q > PW'(QCLAMP)) ? QCLAMP : md_q[W+1:0];
        fin_sum   = r_neg ? ((W+3)'(r_anchor) - $signed({1'b0, q_clamped}))
                          : ((W+3)'(r_anchor) + $signed({1'b0, q_clamped}));
    end

    assign md_ctrl.go       = r_go;
    assign md_ctrl.div_only = r_div_only;

    pcm_muldiv #(.VALUE_WIDTH(VALUE_WIDTH)) u_muldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (md_ctrl),
        .i_ma       (r_ma),
        .i_mb       (r_mb),
        .i_md       (r_md),
        .i_dividend (r_dividend),
        .o_done     (md_done),
        .o_q        (md_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail && it_cmd == pcm_pkg::CMD_MAP) begin
                        r_x <= it_sample;
                        r_c <= c_eff;
                        r_k <= '0;
                        if (c_eff == '0) begin
                            r_y     <= '0;
                            r_st    <= pcm_pkg::ST_EMPTY;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_k <= r_k + 1'b1;
                    unique case (r_k[2:0])
                        3'd1: begin r_f0 <= cur_f; r_r0 <= cur_r; end
                        3'd2: begin r_f1 <= cur_f; r_r1 <= cur_r; end
                        3'd3: begin r_fp <= cur_f; r_rp <= cur_r; end
                        3'd4: begin
                            r_fl    <= cur_f;
                            r_rl    <= cur_r;
                            r_state <= S_DEC;
                        end
                        default: ;
                    endcase
                end
                S_DEC: begin
                    r_st <= pcm_pkg::ST_OK;
                    if (is_inside) begin
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (pol == pcm_pkg::POL_UNCHANGED) begin
                        r_y     <= r_x;
                        r_state <= S_OUT;
                    end else if (pol == pcm_pkg::POL_ZERO) begin
                        r_y     <= nref;
                        r_state <= S_OUT;
                    end else if (pol == pcm_pkg::POL_ONE_TO_ONE || r_c == CW'(1)) begin
                        r_y     <= f_sat(o2o);
                        r_state <= S_OUT;
                    end else if (sel_dd == '0) begin
                        r_y     <= nref;
                        r_st    <= pcm_pkg::ST_ZERO_DEN;
                        r_state <= S_OUT;
                    end else begin
                        r_ma       <= mag_dy;
                        r_mb       <= mag_dx;
                        r_md       <= mag_dd;
                        r_neg      <= sel_dy[D-1] ^ sel_dx[D-1] ^ sel_dd[D-1];
                        r_anchor   <= nref;
                        r_div_only <= 1'b0;
                        r_go       <= 1'b1;
                        r_state    <= S_MD;
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k != '0) begin
                        // cur_f/cur_r belong to point r_k-1
                        if (cur_f == r_x) begin
                            r_sum <= r_sum + SW'(cur_r);
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (r_k != (CW+1)'(1) && !r_found &&
                            (cur_f > r_x || r_k == (CW+1)'(r_c))) begin
                            r_found <= 1'b1;
                            r_lf    <= r_pf;
                            r_lr    <= r_pr;
                            r_uf    <= cur_f;
                            r_ur    <= cur_r;
                        end
                        r_pf <= cur_f;
                        r_pr <= cur_r;
                        if (r_k == (CW+1)'(r_c)) r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    if (r_cnt != '0) begin
                        r_dividend <= PW'($unsigned(sum_mag));
                        r_md       <= D'(r_cnt);
                        r_neg      <= r_sum[SW-1];
                        r_anchor   <= '0;
                        r_div_only <= 1'b1;
                        r_go       <= 1'b1;
                        r_state    <= S_MD;
                    end else if (sel_dd == '0) begin
                        r_y     <= r_lr;
                        r_st    <= pcm_pkg::ST_ZERO_DEN;
                        r_state <= S_OUT;
                    end else begin
                        r_ma       <= mag_dy;
                        r_mb       <= mag_dx;
                        r_md       <= mag_dd;
                        r_neg      <= sel_dy[D-1] ^ sel_dx[D-1] ^ sel_dd[D-1];
                        r_anchor   <= r_lr;
                        r_div_only <= 1'b0;
                        r_go       <= 1'b1;
                        r_state    <= S_MD;
                    end
                end
                S_MD: begin
                    if (md_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_y     <= f_sat(fin_sum);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_val   <= r_y;
                        r_out_st    <= r_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/core/piecewise_curve_mapper.sv
// Piecewise linear curve mapper.
// Input channel (i_valid / o_stall) carries load beats (i_command 0: write one curve
// point at i_point_index) and map beats (i_command 1: map i_sample). A beat is taken
// when i_valid is high and o_stall is low; a four-entry queue decouples intake from
// the execution sequencer.
// Output channel (o_valid / i_stall) returns one beat per map: o_mapped_value and
// o_status. A finished result sits in the output register while the sequencer
// goes on with queued loads and the next map.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the below-range rule,
// the above-range rule and the point count; write it only while the block is idle.
// A load retires as it is popped from the queue. A map is issued, reads the curve end
// points and classifies the sample; a sample inside the curve is then scanned over the C
// curve points. A slope step or a mean over exact hits goes through the shared serial
// multiply/divide unit (shift-add unless a mean, then divide) and a finish step. An empty
// curve answers ST_EMPTY without reads. Maps run one at a time.
// Reset clears the queue, the sequencer, the output register and the config
// registers. Curve points are undefined until loaded. While i_stall holds, the
// result waits and, once the sequencer has a second result, o_stall rises as the
// queue fills.
module piecewise_curve_mapper #(
    parameter int MAX_POINTS    = pcm_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH   = pcm_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = pcm_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_command,
    input  logic [pcm_pkg::IDX_W-1:0]        i_point_index,
    input  logic signed [VALUE_WIDTH-1:0]    i_ref_value,
    input  logic signed [VALUE_WIDTH-1:0]    i_fcst_value,
    input  logic signed [VALUE_WIDTH-1:0]    i_sample,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [VALUE_WIDTH-1:0]    o_mapped_value,
    output logic [pcm_pkg::STATUS_W-1:0]     o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcm_pkg::COUNT_W-1:0]      i_cfg_data
);
    // Fixed-point scale is carried by the data only; no stage rescales by it.
    localparam int ITEM_W = 1 + pcm_pkg::IDX_W + 3 * VALUE_WIDTH + 0 * FRACTION_BITS;

    logic [pcm_pkg::POL_W-1:0]   r_pol_below;
    logic [pcm_pkg::POL_W-1:0]   r_pol_above;
    logic [pcm_pkg::COUNT_W-1:0] r_point_count;
    logic                        q_avail;
    logic [ITEM_W-1:0]           q_item;
    logic                        q_pop;
    logic [VALUE_WIDTH-1:0]      mapped;

    assign o_cfg_ready    = 1'b1;
    assign o_mapped_value = $signed(mapped);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol_below   <= pcm_pkg::POL_UNCHANGED;
            r_pol_above   <= pcm_pkg::POL_UNCHANGED;
            r_point_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pcm_pkg::CFG_POL_BELOW: r_pol_below   <= i_cfg_data[pcm_pkg::POL_W-1:0];
                pcm_pkg::CFG_POL_ABOVE: r_pol_above   <= i_cfg_data[pcm_pkg::POL_W-1:0];
                pcm_pkg::CFG_COUNT:     r_point_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pcm_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_point_index (i_point_index),
        .i_ref_value   (i_ref_value),
        .i_fcst_value  (i_fcst_value),
        .i_sample      (i_sample),
        .o_avail       (q_avail),
        .o_item        (q_item),
        .i_pop         (q_pop)
    );

    pcm_back #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .i_pol_below    (r_pol_below),
        .i_pol_above    (r_pol_above),
        .i_point_count  (r_point_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mapped_value (mapped),
        .o_status       (o_status)
    );
endmodule

FILE: bench/pcm_checker.sv
module pcm_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_command,
    input  logic [pcm_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [31:0]                 i_ref_value,
    input  logic signed [31:0]                 i_fcst_value,
    input  logic signed [31:0]                 i_sample,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [31:0]                 i_mapped_value,
    input  logic [pcm_pkg::STATUS_W-1:0]       i_status,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcm_pkg::COUNT_W-1:0]        i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam logic [127:0] DELTA_CLAMP = 128'd1 << 33;

    typedef struct {
        logic signed [31:0]           value;
        logic [pcm_pkg::STATUS_W-1:0] status;
    } t_mapped;

    longint                      pt_ref [64];
    longint                      pt_fcst [64];
    logic [pcm_pkg::POL_W-1:0]   rule_below;
    logic [pcm_pkg::POL_W-1:0]   rule_above;
    logic [pcm_pkg::COUNT_W-1:0] points_used;
    t_mapped                     mapped_q [$];
    int                          errors;

    assign o_errors = errors;

    function automatic longint saturate(input longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    // trunc(a*b/d), magnitude clamped to 2^33
    function automatic longint scaled_step(input longint a, input longint b, input longint d);
        logic         neg;
        logic [127:0] ua, ub, ud, q;
        neg = (a < 0) ^ (b < 0) ^ (d < 0);
        ua  = (a < 0) ? 128'(-a) : 128'(a);
        ub  = (b < 0) ? 128'(-b) : 128'(b);
        ud  = (d < 0) ? 128'(-d) : 128'(d);
        q   = (ua * ub) / ud;
        if (q > DELTA_CLAMP) q = DELTA_CLAMP;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_mapped map_sample(input longint x);
        t_mapped                   r;
        int                        c, i, e, hits;
        longint                    sum, dd, dy, n_ref, n_fcst, y;
        logic [pcm_pkg::POL_W-1:0] rule;
        logic                      below;
        r.status = pcm_pkg::ST_OK;
        c = (points_used > 64) ? 64 : int'(points_used);
        if (c == 0) begin
            y = 0;
            r.status = pcm_pkg::ST_EMPTY;
        end else if (x >= pt_fcst[0] && x <= pt_fcst[c-1]) begin
            sum  = 0;
            hits = 0;
            for (i = 0; i < c; i++) begin
                if (pt_fcst[i] == x) begin
                    sum += pt_ref[i];
                    hits++;
                end
            end
            if (hits != 0) begin
                y = sum / longint'(hits);
            end else begin
                i = 1;
                while (i < c - 1 && !(pt_fcst[i] > x)) i++;
                if (i >= c) i = c - 1;
                dd = pt_fcst[i] - pt_fcst[i-1];
                if (dd == 0) begin
                    r.status = pcm_pkg::ST_ZERO_DEN;
                    y = pt_ref[i-1];
                end else begin
                    y = saturate(pt_ref[i-1] + scaled_step(pt_ref[i] - pt_ref[i-1],
                                 x - pt_fcst[i-1], dd));
                end
            end
        end else begin
            below  = (x <= pt_fcst[0]);
            e      = below ? 0 : c - 1;
            n_ref  = pt_ref[e];
            n_fcst = pt_fcst[e];
            rule   = below ? rule_below : rule_above;
            if (rule > pcm_pkg::POL_NEAREST) rule = pcm_pkg::POL_UNCHANGED;
            if (rule == pcm_pkg::POL_UNCHANGED) begin
                y = x;
            end else if (rule == pcm_pkg::POL_ZERO) begin
                y = n_ref;
            end else if (rule == pcm_pkg::POL_ONE_TO_ONE || c <= 1) begin
                y = saturate(n_ref + (x - n_fcst));
            end else begin
                if (rule == pcm_pkg::POL_MEAN) begin
                    dy = pt_ref[c-1] - pt_ref[0];
                    dd = pt_fcst[c-1] - pt_fcst[0];
                end else if (below) begin
                    dy = pt_ref[1] - pt_ref[0];
                    dd = pt_fcst[1] - pt_fcst[0];
                end else begin
                    dy = pt_ref[c-1] - pt_ref[c-2];
                    dd = pt_fcst[c-1] - pt_fcst[c-2];
                end
                if (dd == 0) begin
                    r.status = pcm_pkg::ST_ZERO_DEN;
                    y = n_ref;
                end else begin
                    y = saturate(n_ref + scaled_step(dy, x - n_fcst, dd));
                end
            end
        end
        r.value = y[31:0];
        return r;
    endfunction

    initial begin
        errors = 0;
        for (int k = 0; k < 64; k++) begin
            pt_ref[k]  = 0;
            pt_fcst[k] = 0;
        end
    end

    always @(posedge i_clk) begin
        t_mapped got, want;
        if (!i_rst_n) begin
            rule_below  = pcm_pkg::POL_UNCHANGED;
            rule_above  = pcm_pkg::POL_UNCHANGED;
            points_used = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pcm_pkg::CFG_POL_BELOW: rule_below  = i_cfg_data[pcm_pkg::POL_W-1:0];
                    pcm_pkg::CFG_POL_ABOVE: rule_above  = i_cfg_data[pcm_pkg::POL_W-1:0];
                    pcm_pkg::CFG_COUNT:     points_used = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_command == pcm_pkg::CMD_LOAD) begin
                    pt_ref[i_point_index]  = longint'(i_ref_value);
                    pt_fcst[i_point_index] = longint'(i_fcst_value);
                end else begin
                    mapped_q.insert(mapped_q.size(), map_sample(longint'(i_sample)));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got.value  = i_mapped_value;
                got.status = i_status;
                if (mapped_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result beat: value %0d status %0d",
                                 got.value, got.status);
                    errors++;
                end else begin
                    want = mapped_q.pop_front();
                    if (got.value !== want.value || got.status !== want.status) begin
                        if (errors < 10)
                            $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                                     want.value, got.value, want.status, got.status);
                        errors++;
                    end
                end
            end
        end
        o_pending = mapped_q.size();
    end

endmodule

FILE: bench/tb_piecewise_curve_mapper.sv
module tb_piecewise_curve_mapper;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_command;
    logic [pcm_pkg::IDX_W-1:0]         i_point_index;
    logic signed [31:0]                i_ref_value;
    logic signed [31:0]                i_fcst_value;
    logic signed [31:0]                i_sample;
    logic                              o_valid;
    logic                              i_stall;
    logic signed [31:0]                o_mapped_value;
    logic [pcm_pkg::STATUS_W-1:0]      o_status;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [pcm_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [pcm_pkg::COUNT_W-1:0]       i_cfg_data;

    int      errors, pending;
    int      send_idle_pct, recv_idle_pct;
    logic    hold_req, hold_taken, arm_hold;
    logic    in_beat, cfg_beat;
    longint  pts_fcst [64];
    longint  pts_ref [64];

    piecewise_curve_mapper u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_point_index  (i_point_index),
        .i_ref_value    (i_ref_value),
        .i_fcst_value   (i_fcst_value),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mapped_value (o_mapped_value),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    pcm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_command      (i_command),
        .i_point_index  (i_point_index),
        .i_ref_value    (i_ref_value),
        .i_fcst_value   (i_fcst_value),
        .i_sample       (i_sample),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_mapped_value (o_mapped_value),
        .i_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 4_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // beat flags, read at the falling edge
    always @(posedge i_clk) begin
        in_beat  <= i_valid && !o_stall;
        cfg_beat <= i_cfg_valid && o_cfg_ready;
    end

    // result side: random stall, plus one long hold to back up the input
    initial begin
        i_stall    = 1'b0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_stall    = 1'b1;
                repeat (1000) @(negedge i_clk);
            end
            i_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic send_beat(input logic cmd, input logic [pcm_pkg::IDX_W-1:0] idx,
                             input logic signed [31:0] ref_v, input logic signed [31:0] fcst_v,
                             input logic signed [31:0] smp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_command     = cmd;
        i_point_index = idx;
        i_ref_value   = ref_v;
        i_fcst_value  = fcst_v;
        i_sample      = smp;
        do @(negedge i_clk); while (!in_beat);
    endtask

    task automatic cfg_write(input logic [pcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcm_pkg::COUNT_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(negedge i_clk); while (!cfg_beat);
        i_cfg_valid = 1'b0;
    endtask

    // wait for every result, then let a trailing load retire
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic load_curve(input int n, input int shape);
        longint base, tmp;
        logic   full_ref;
        base     = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        full_ref = (shape == 1) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++) begin
            case (shape)
                0: pts_fcst[k] = (k == 0) ? base : pts_fcst[k-1] + $urandom_range(1, 1 << 18);
                1: pts_fcst[k] = longint'($signed($urandom()));
                2: pts_fcst[k] = (k == 0) ? base : pts_fcst[k-1] +
                                 (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 16));
                3: pts_fcst[k] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
                default: pts_fcst[k] = base;
            endcase
            if (full_ref)
                pts_ref[k] = longint'($signed($urandom()));
            else
                pts_ref[k] = ((k == 0) ? base : pts_ref[k-1]) +
                             longint'($urandom_range(0, 1 << 20)) - (1 << 19);
            pts_ref[k] = clip32(pts_ref[k]);
        end
        if (shape == 1) begin
            for (int a = 1; a < n; a++) begin
                for (int b = a; b > 0 && pts_fcst[b-1] > pts_fcst[b]; b--) begin
                    tmp           = pts_fcst[b];
                    pts_fcst[b]   = pts_fcst[b-1];
                    pts_fcst[b-1] = tmp;
                end
            end
        end
        for (int k = 0; k < n; k++)
            send_beat(pcm_pkg::CMD_LOAD, k[pcm_pkg::IDX_W-1:0], pts_ref[k][31:0],
                      pts_fcst[k][31:0], $urandom());
    endtask

    function automatic logic signed [31:0] pick_sample(input int n);
        longint v;
        int     k;
        if (n == 0) return $urandom();
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: v = pts_fcst[k];
            1, 2, 3: v = (k < n - 1) ?
                         pts_fcst[k] + ((pts_fcst[k+1] - pts_fcst[k]) * $urandom_range(0, 255)) / 256
                         : pts_fcst[k];
            4: v = pts_fcst[0] - $urandom_range(0, 1 << 20);
            5: v = pts_fcst[n-1] + $urandom_range(0, 1 << 20);
            6: v = -64'sd2147483648;
            7: v = 64'sd2147483647;
            default: v = longint'($signed($urandom()));
        endcase
        v = clip32(v);
        return v[31:0];
    endfunction

    task automatic run_set(input logic [pcm_pkg::POL_W-1:0] below,
                           input logic [pcm_pkg::POL_W-1:0] above,
                           input int count, input int shape, input int maps);
        int n;
        n = (count > 64) ? 64 : count;
        drain();
        cfg_write(pcm_pkg::CFG_POL_BELOW, {4'($urandom_range(0, 15)), below});
        cfg_write(pcm_pkg::CFG_POL_ABOVE, {4'($urandom_range(0, 15)), above});
        cfg_write(pcm_pkg::CFG_COUNT, count[pcm_pkg::COUNT_W-1:0]);
        if (n > 0) load_curve(n, shape);
        for (int m = 0; m < maps; m++) begin
            // start the long hold once the sender is streaming
            if (arm_hold && m == 0) hold_req = 1'b1;
            // points past the curve in use can be overwritten freely
            if (n < 64 && $urandom_range(0, 11) == 0)
                send_beat(pcm_pkg::CMD_LOAD, 6'($urandom_range(n, 63)), $urandom(), $urandom(),
                          $urandom());
            else
                send_beat(pcm_pkg::CMD_MAP, 6'($urandom()), $urandom(), $urandom(),
                          pick_sample(n));
        end
    endtask

    initial begin
        int count, r;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = pcm_pkg::CMD_LOAD;
        i_point_index = '0;
        i_ref_value   = '0;
        i_fcst_value  = '0;
        i_sample      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pcm_pkg::CFG_POL_BELOW;
        i_cfg_data    = '0;
        hold_req      = 1'b0;
        arm_hold      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed corners
        run_set(pcm_pkg::POL_UNCHANGED, pcm_pkg::POL_UNCHANGED, 0, 0, 2);
        run_set(pcm_pkg::POL_ONE_TO_ONE, pcm_pkg::POL_NEAREST, 1, 0, 3);
        run_set(pcm_pkg::POL_ZERO, pcm_pkg::POL_MEAN, 1, 0, 2);
        run_set(pcm_pkg::POL_MEAN, pcm_pkg::POL_NEAREST, 4, 4, 3);
        run_set(pcm_pkg::POL_NEAREST, pcm_pkg::POL_MEAN, 6, 2, 3);
        run_set(3'd5, 3'd7, 5, 3, 3);
        run_set(pcm_pkg::POL_MEAN, pcm_pkg::POL_ONE_TO_ONE, 127, 1, 3);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 38 : 0;
            for (int s = 0; s < 10; s++) begin
                r = $urandom_range(0, 19);
                count = (r == 0) ? 0 : (r == 1) ? 64 : (r == 2) ? $urandom_range(65, 127)
                        : $urandom_range(1, 8);
                arm_hold = (phase == 2 && s == 0);
                run_set(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), count,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : $urandom_range(0, 1),
                        arm_hold ? 16 : 8);
            end
        end

        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
